/* design/esfc_pkg.sv */
// ----------------------------------------------------------------------------
// Elevator stepper floor controller package
// Shared constants, request and mode codes, and the coil drive table.
// ----------------------------------------------------------------------------
package esfc_pkg;

  // Motor steps that carry the car over one floor.
  localparam int STEPS_PER_FLOOR = 4096;
  // Highest floor number that a request may name.
  localparam int FLOOR_COUNT = 8;

  localparam int REQ_W   = 2;
  localparam int FLOOR_W = 4;
  localparam int COIL_W  = 4;
  localparam int MODE_W  = 2;
  localparam int PHASE_W = 3;
  localparam int GAP_W   = 3;
  localparam int COUNT_W = 15;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Request kinds carried on the input tuser.
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FLOOR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // Motion modes.
  localparam logic [MODE_W-1:0] MODE_STANDBY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UP      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOWN    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ARRIVED = 2'd3;

  // Bit positions of the result fields inside the output tdata.
  localparam int OUT_COIL_LSB  = 0;
  localparam int OUT_MODE_LSB  = 4;
  localparam int OUT_SHOWN_LSB = 6;
  localparam int OUT_GOAL_LSB  = 10;
  localparam int OUT_PULSE_BIT = 14;

  // Half-step coil pattern for each phase.
  function automatic logic [COIL_W-1:0] coil_of_phase(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'd1;
      3'd1:    pat = 4'd3;
      3'd2:    pat = 4'd2;
      3'd3:    pat = 4'd6;
      3'd4:    pat = 4'd4;
      3'd5:    pat = 4'd12;
      3'd6:    pat = 4'd8;
      default: pat = 4'd9;
    endcase
    return pat;
  endfunction

endpackage

/* design/elevator_stepper_floor_controller_top.sv */
// ----------------------------------------------------------------------------
// Elevator stepper floor controller
// Turns floor requests, stop requests and step ticks into half-step coil
// drive, motion mode and floor display for one elevator car.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_*     | in        | tuser = request kind, tdata = target floor
//  m_*     | out       | tdata = coil, mode, shown floor, goal floor, arrival
//
// Each accepted word updates the controller state and loads its result into the
// output register in the same cycle; one word per cycle while the output is taken.
// The output register is the only stage, so s_tready stays high while the
// result is taken or the register is empty.
// Reset is synchronous and leaves the car in standby at floor one, coils off.
// A stalled output holds its word and stops input acceptance until taken.
module elevator_stepper_floor_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [3:0] target_floor, [7:4] zero
  input  logic [esfc_pkg::IN_DATA_W-1:0]     s_tdata,
  // [1:0] req_type
  input  logic [esfc_pkg::REQ_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [3:0] coil_pattern, [5:4] motion_mode, [9:6] shown_floor,
  // [13:10] goal_floor, [14] arrived_pulse, [15] zero
  output logic [esfc_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int SUB_W  = $clog2(esfc_pkg::STEPS_PER_FLOOR);
  localparam int PROD_W = esfc_pkg::GAP_W + SUB_W + 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(esfc_pkg::STEPS_PER_FLOOR - 1);
  localparam logic [esfc_pkg::FLOOR_W-1:0] FLOOR_MAX =
    esfc_pkg::FLOOR_W'(esfc_pkg::FLOOR_COUNT);

  // Controller state.
  logic [esfc_pkg::MODE_W-1:0]  mode, mode_next;
  logic [esfc_pkg::PHASE_W-1:0] phase, phase_next;
  logic [esfc_pkg::COUNT_W-1:0] step_count, step_count_next;
  logic [SUB_W-1:0]             floor_steps, floor_steps_next;
  logic [esfc_pkg::FLOOR_W-1:0] last_target, last_target_next;
  logic [esfc_pkg::GAP_W-1:0]   trip_span, trip_span_next;
  logic [esfc_pkg::FLOOR_W-1:0] display_floor, display_floor_next;
  logic [esfc_pkg::COIL_W-1:0]  coil_hold, coil_hold_next;
  logic                         pulse_next;

  logic                         accept;
  logic [esfc_pkg::REQ_W-1:0]   req;
  logic [esfc_pkg::FLOOR_W-1:0] tgt;
  logic [PROD_W-1:0]            limit;
  logic                         moving;
  logic                         going_up;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign req      = s_tuser;
  assign tgt      = s_tdata[esfc_pkg::FLOOR_W-1:0];
  assign moving   = (mode == esfc_pkg::MODE_UP) || (mode == esfc_pkg::MODE_DOWN);
  assign going_up = (mode == esfc_pkg::MODE_UP);
  assign limit    = PROD_W'(trip_span) * PROD_W'(esfc_pkg::STEPS_PER_FLOOR);

  // Next state for one request word.
  always_comb begin
    mode_next          = mode;
    phase_next         = phase;
    step_count_next    = step_count;
    floor_steps_next   = floor_steps;
    last_target_next   = last_target;
    trip_span_next     = trip_span;
    display_floor_next = display_floor;
    coil_hold_next     = coil_hold;
    pulse_next         = 1'b0;
    case (req)
      esfc_pkg::REQ_FLOOR: begin
        // Out-of-range floors and the current target are ignored.
        if (tgt != '0 && tgt <= FLOOR_MAX && tgt != last_target) begin
          display_floor_next = last_target;
          last_target_next   = tgt;
          if (last_target > tgt) begin
            trip_span_next = esfc_pkg::GAP_W'(last_target - tgt);
            mode_next      = esfc_pkg::MODE_DOWN;
          end else begin
            trip_span_next = esfc_pkg::GAP_W'(tgt - last_target);
            mode_next      = esfc_pkg::MODE_UP;
          end
        end
      end
      esfc_pkg::REQ_STOP: begin
        mode_next = esfc_pkg::MODE_STANDBY;
      end
      esfc_pkg::REQ_TICK: begin
        if (moving) begin
          coil_hold_next = esfc_pkg::coil_of_phase(phase);
          if (PROD_W'(step_count) <= limit) begin
            step_count_next  = step_count + 1'b1;
            floor_steps_next = (floor_steps == SUB_LAST) ? '0 : floor_steps + 1'b1;
            phase_next       = going_up ? phase + 1'b1 : phase - 1'b1;
            // One floor's worth of steps completed.
            if (floor_steps == SUB_LAST) begin
              display_floor_next = going_up ? display_floor + 1'b1
                                            : display_floor - 1'b1;
            end
          end else begin
            phase_next       = '0;
            step_count_next  = '0;
            floor_steps_next = '0;
            mode_next        = esfc_pkg::MODE_ARRIVED;
            pulse_next       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers and output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= esfc_pkg::MODE_STANDBY;
      phase         <= '0;
      step_count    <= '0;
      floor_steps   <= '0;
      last_target   <= esfc_pkg::FLOOR_W'(1);
      trip_span     <= '0;
      display_floor <= esfc_pkg::FLOOR_W'(1);
      coil_hold     <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        mode          <= mode_next;
        phase         <= phase_next;
        step_count    <= step_count_next;
        floor_steps   <= floor_steps_next;
        last_target   <= last_target_next;
        trip_span     <= trip_span_next;
        display_floor <= display_floor_next;
        coil_hold     <= coil_hold_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, pulse_next, last_target_next, display_floor_next,
                  mode_next, coil_hold_next};
    end
  end

endmodule

/* design/esfc_checker.sv */
// ----------------------------------------------------------------------------
// Elevator stepper floor controller port checker
// Watches the top level's ports for stream and result consistency.
// ----------------------------------------------------------------------------
module esfc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [esfc_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic [esfc_pkg::MODE_W-1:0]  out_mode;
  logic [esfc_pkg::FLOOR_W-1:0] out_goal;
  logic                         out_pulse;

  assign out_mode  = m_tdata[esfc_pkg::OUT_MODE_LSB +: esfc_pkg::MODE_W];
  assign out_goal  = m_tdata[esfc_pkg::OUT_GOAL_LSB +: esfc_pkg::FLOOR_W];
  assign out_pulse = m_tdata[esfc_pkg::OUT_PULSE_BIT];

  // A stalled word stays put until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // Every accepted input word yields a result word next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

  // The arrival flag only comes with arrival mode.
  a_pulse_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_pulse |-> out_mode == esfc_pkg::MODE_ARRIVED)
    else $error("arrival flag outside arrival mode");

  // The goal floor always stays a valid floor.
  a_goal_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_goal != '0 &&
      out_goal <= esfc_pkg::FLOOR_W'(esfc_pkg::FLOOR_COUNT))
    else $error("goal floor out of range");

  // Input is held off only while an untaken word waits.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind elevator_stepper_floor_controller_top esfc_checker u_esfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/tb_elevator_stepper_floor_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator stepper floor controller testbench
// Sends floor requests, stop requests, step ticks and unused codes into the
// controller and keeps its own model of the car: mode, phase, step count,
// target, floor gap, shown floor and held coils. Each input word produces one
// expected status word, and every output word is checked field by field
// against the oldest expected one. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_elevator_stepper_floor_controller_top;

  // The request code that the controller does not use.
  localparam logic [esfc_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
  // Input words sent over the whole run.
  localparam int TOTAL_WORDS = 1450;

  // One status word as the controller reports it.
  typedef struct packed {
    logic [esfc_pkg::COIL_W-1:0]  coil;
    logic [esfc_pkg::MODE_W-1:0]  mode;
    logic [esfc_pkg::FLOOR_W-1:0] shown;
    logic [esfc_pkg::FLOOR_W-1:0] goal;
    logic                         pulse;
  } car_status_t;

  // Half-step coil drive per phase, first coil in bit 0.
  localparam logic [esfc_pkg::COIL_W-1:0] HALF_STEP_COILS [8] = '{
    4'b0001, 4'b0011, 4'b0010, 4'b0110, 4'b0100, 4'b1100, 4'b1000, 4'b1001
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // [3:0] target_floor, [7:4] zero
  logic [esfc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  // [1:0] req_type
  logic [esfc_pkg::REQ_W-1:0]      s_tuser = esfc_pkg::REQ_TICK;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // [3:0] coil_pattern, [5:4] motion_mode, [9:6] shown_floor,
  // [13:10] goal_floor, [14] arrived_pulse, [15] zero
  logic [esfc_pkg::OUT_DATA_W-1:0] m_tdata;

  // Model of the car.
  logic [esfc_pkg::MODE_W-1:0]  car_mode;
  logic [esfc_pkg::PHASE_W-1:0] car_phase;
  logic [esfc_pkg::COUNT_W-1:0] car_count;
  logic [esfc_pkg::FLOOR_W-1:0] car_goal;
  logic [esfc_pkg::GAP_W-1:0]   car_gap;
  logic [esfc_pkg::FLOOR_W-1:0] car_shown;
  logic [esfc_pkg::COIL_W-1:0]  car_coil;

  car_status_t pending_status [$];
  int          fails = 0;
  int          sent_words = 0;
  int          source_quiet = 0;
  int          sink_quiet = 0;
  int          sink_stall = 0;
  int          sink_hold_req = 0;

  elevator_stepper_floor_controller_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Apply one request to the car model and return the status it reports.
  function automatic car_status_t advance_car(input logic [esfc_pkg::REQ_W-1:0] req,
                                              input logic [esfc_pkg::FLOOR_W-1:0] flr);
    car_status_t st;
    logic        arrived;
    int          limit;
    arrived = 1'b0;
    case (req)
      esfc_pkg::REQ_FLOOR: begin
        if (flr >= 1 && flr <= esfc_pkg::FLOOR_COUNT && flr != car_goal) begin
          car_shown = car_goal;
          if (car_goal > flr) begin
            car_gap  = esfc_pkg::GAP_W'(car_goal - flr);
            car_mode = esfc_pkg::MODE_DOWN;
          end else begin
            car_gap  = esfc_pkg::GAP_W'(flr - car_goal);
            car_mode = esfc_pkg::MODE_UP;
          end
          car_goal = flr;
        end
      end
      esfc_pkg::REQ_STOP: begin
        car_mode = esfc_pkg::MODE_STANDBY;
      end
      esfc_pkg::REQ_TICK: begin
        if (car_mode == esfc_pkg::MODE_UP || car_mode == esfc_pkg::MODE_DOWN) begin
          car_coil = HALF_STEP_COILS[car_phase];
          limit = int'(car_gap) * esfc_pkg::STEPS_PER_FLOOR;
          if (int'(car_count) <= limit) begin
            car_count = car_count + 1'b1;
            car_phase = (car_mode == esfc_pkg::MODE_UP) ? car_phase + 1'b1
                                                        : car_phase - 1'b1;
            // The display moves once per floor's worth of steps.
            if (int'(car_count) % esfc_pkg::STEPS_PER_FLOOR == 0) begin
              car_shown = (car_mode == esfc_pkg::MODE_UP) ? car_shown + 1'b1
                                                          : car_shown - 1'b1;
            end
          end else begin
            car_phase = '0;
            car_count = '0;
            car_mode  = esfc_pkg::MODE_ARRIVED;
            arrived   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    st.coil  = car_coil;
    st.mode  = car_mode;
    st.shown = car_shown;
    st.goal  = car_goal;
    st.pulse = arrived;
    return st;
  endfunction

  // Idle cycles before the next input word: mostly none, some short, few long.
  function automatic int source_gap();
    int pick;
    if (source_quiet > 0) begin
      source_quiet--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) source_quiet = $urandom_range(20, 80);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Stall cycles on the output side, drawn the same way.
  function automatic int sink_gap();
    int pick;
    if (sink_quiet > 0) begin
      sink_quiet--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) sink_quiet = $urandom_range(20, 80);
    if (pick < 65) return 0;
    if (pick < 96) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Offer one word and record its expected status once it is taken.
  task automatic send_word(input logic [esfc_pkg::REQ_W-1:0] req,
                           input logic [esfc_pkg::FLOOR_W-1:0] flr);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {{(esfc_pkg::IN_DATA_W-esfc_pkg::FLOOR_W){1'b0}}, flr};
    do @(posedge clk); while (!s_tready);
    sent_words++;
    pending_status.push_back(advance_car(req, flr));
  endtask

  // A short run of ticks with random unused floor fields.
  task automatic send_ticks(input int count);
    repeat (count) send_word(esfc_pkg::REQ_TICK, esfc_pkg::FLOOR_W'($urandom_range(0, 15)));
  endtask

  // Stop offering words and wait for every expected status word.
  task automatic drain_status();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // Output side: check each taken word and decide the next ready.
  always @(posedge clk) begin
    car_status_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_status.size() == 0) begin
          $display("%0t: status word with none expected, expected none, actual %h",
                   $time, m_tdata);
          fails++;
        end else begin
          want = pending_status.pop_front();
          compare_field("coil_pattern", 32'(want.coil),
                        32'(m_tdata[esfc_pkg::OUT_COIL_LSB +: esfc_pkg::COIL_W]));
          compare_field("motion_mode", 32'(want.mode),
                        32'(m_tdata[esfc_pkg::OUT_MODE_LSB +: esfc_pkg::MODE_W]));
          compare_field("shown_floor", 32'(want.shown),
                        32'(m_tdata[esfc_pkg::OUT_SHOWN_LSB +: esfc_pkg::FLOOR_W]));
          compare_field("goal_floor", 32'(want.goal),
                        32'(m_tdata[esfc_pkg::OUT_GOAL_LSB +: esfc_pkg::FLOOR_W]));
          compare_field("arrived_pulse", 32'(want.pulse),
                        32'(m_tdata[esfc_pkg::OUT_PULSE_BIT]));
        end
      end
      if (sink_hold_req > 0) begin
        sink_stall = sink_hold_req;
        sink_hold_req = 0;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_stall = sink_gap();
      end
    end
  end

  // Requests that change nothing right after reset, and the same-floor case.
  task automatic test_quiet_requests();
    send_word(esfc_pkg::REQ_TICK, 4'd0);
    send_word(REQ_SPARE, 4'd15);
    send_word(esfc_pkg::REQ_STOP, 4'd7);
    send_word(esfc_pkg::REQ_FLOOR, 4'd0);
    send_word(esfc_pkg::REQ_FLOOR, 4'd9);
    send_word(esfc_pkg::REQ_FLOOR, 4'd15);
    send_word(esfc_pkg::REQ_FLOOR, 4'd1);
    send_word(esfc_pkg::REQ_TICK, 4'd10);
  endtask

  // One floor up: phase advance, a repeated target, then stop with ticks ignored.
  task automatic test_one_floor_up();
    send_word(esfc_pkg::REQ_FLOOR, 4'd2);
    send_ticks(40);
    send_word(esfc_pkg::REQ_FLOOR, 4'd2);
    send_word(esfc_pkg::REQ_STOP, 4'd0);
    send_ticks(3);
  endtask

  // Reversal while moving, backward phase wrap, stop with kept count.
  task automatic test_turnaround();
    send_word(esfc_pkg::REQ_FLOOR, 4'd1);
    repeat (300) send_word(esfc_pkg::REQ_TICK, 4'd5);
    send_word(esfc_pkg::REQ_STOP, 4'd0);
    repeat (3) send_word(esfc_pkg::REQ_TICK, 4'd0);
    send_word(esfc_pkg::REQ_FLOOR, 4'd3);
    repeat (50) send_word(esfc_pkg::REQ_TICK, 4'd0);
    send_word(REQ_SPARE, 4'd8);
    send_word(esfc_pkg::REQ_FLOOR, 4'd2);
    send_ticks(30);
  endtask

  // The widest floor gap in both directions.
  task automatic test_full_span();
    send_word(esfc_pkg::REQ_FLOOR, 4'd1);
    send_ticks(5);
    send_word(esfc_pkg::REQ_FLOOR, 4'd8);
    send_ticks(20);
    send_word(esfc_pkg::REQ_FLOOR, 4'd1);
    send_ticks(20);
  endtask

  // The output holds off for a long stretch while words keep coming, then
  // the input pauses until every status word has been taken.
  task automatic test_output_stall();
    drain_status();
    sink_hold_req = 300;
    send_word(esfc_pkg::REQ_FLOOR, 4'd4);
    send_ticks(20);
    send_word(esfc_pkg::REQ_STOP, 4'd0);
    send_word(esfc_pkg::REQ_FLOOR, 4'd3);
    drain_status();
  endtask

  // Random trips: mostly valid floor requests followed by tick bursts, with
  // stops, unused codes and bad floors mixed in.
  task automatic test_random_traffic();
    int burst;
    int pick;
    logic [esfc_pkg::FLOOR_W-1:0] flr;
    while (sent_words < TOTAL_WORDS) begin
      if ($urandom_range(0, 9) == 0) flr = esfc_pkg::FLOOR_W'($urandom_range(0, 15));
      else flr = esfc_pkg::FLOOR_W'($urandom_range(1, esfc_pkg::FLOOR_COUNT));
      send_word(esfc_pkg::REQ_FLOOR, flr);
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      repeat (burst) begin
        if (sent_words < TOTAL_WORDS) begin
          pick = $urandom_range(0, 39);
          flr  = esfc_pkg::FLOOR_W'($urandom_range(0, 15));
          if (pick == 0) send_word(esfc_pkg::REQ_STOP, flr);
          else if (pick == 1) send_word(REQ_SPARE, flr);
          else if (pick == 2) send_word(esfc_pkg::REQ_FLOOR, flr);
          else send_word(esfc_pkg::REQ_TICK, flr);
        end
      end
    end
  endtask

  initial begin
    car_mode  = esfc_pkg::MODE_STANDBY;
    car_phase = '0;
    car_count = '0;
    car_goal  = 4'd1;
    car_gap   = '0;
    car_shown = 4'd1;
    car_coil  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_quiet_requests();
    test_one_floor_up();
    test_turnaround();
    test_full_span();
    test_output_stall();
    test_random_traffic();
    drain_status();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
